>>> hw/rtl/tbdc_pkg.sv
`timescale 1ns / 1ps
// Shared constants, codes and microcode program of the two-button dimmer controller.
package tbdc_pkg;

  // Default width of the millisecond time counter.
  localparam int unsigned TIME_BITS_DEF = 32;

  // Configuration port.
  localparam int unsigned CFG_W     = 16;
  localparam int unsigned CFG_IDX_W = 3;

  localparam logic [CFG_IDX_W-1:0] REG_DEBOUNCE = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SHORT    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_CYCLE    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_STEP     = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_ON_LEVEL = 3'd4;

  localparam int unsigned STEP_W = 13;

  // Reset values of the configuration registers.
  localparam logic [CFG_W-1:0]  DEBOUNCE_RST = 16'd50;
  localparam logic [CFG_W-1:0]  SHORT_RST    = 16'd500;
  localparam logic [CFG_W-1:0]  CYCLE_RST    = 16'd4096;
  localparam logic [STEP_W-1:0] STEP_RST     = 13'd16;
  localparam logic [7:0]        ON_LEVEL_RST = 8'hFF;

  localparam logic [7:0] LEVEL_MAX = 8'hFF;
  localparam logic [7:0] LEVEL_MIN = 8'h00;

  // Dimming mode codes as reported on the result.
  localparam logic [1:0] MODE_CONST = 2'd0;
  localparam logic [1:0] MODE_UP    = 2'd1;
  localparam logic [1:0] MODE_DOWN  = 2'd2;

  // Microcode datapath operations.
  typedef enum logic [3:0] {
    OP_NONE,
    OP_TICK,
    OP_BTN_UP,
    OP_BTN_DN,
    OP_SETUP_MOD,
    OP_DIV,
    OP_SETUP_DIV,
    OP_APPLY,
    OP_EMIT
  } op_e;

  // Microcode sequencing conditions.
  typedef enum logic [2:0] {
    JC_NEXT,      // advance
    JC_WAIT_IN,   // hold until a transaction arrives, then advance
    JC_MODE_OFF,  // jump if not dimming
    JC_CYCLE_OFF, // jump if the ramp cycle length is zero
    JC_LOOP,      // jump while the iteration count is nonzero
    JC_WAIT_OUT,  // hold while the result slot is full, then jump
    JC_ALWAYS     // jump
  } jcond_e;

  localparam int unsigned PC_W = 4;

  typedef struct packed {
    op_e             op;
    jcond_e          cond;
    logic [PC_W-1:0] target;
  } uword_t;

  // Program step addresses.
  localparam logic [PC_W-1:0] PC_IDLE     = 4'd0;
  localparam logic [PC_W-1:0] PC_BTN_UP   = 4'd1;
  localparam logic [PC_W-1:0] PC_BTN_DN   = 4'd2;
  localparam logic [PC_W-1:0] PC_CHK_MODE = 4'd3;
  localparam logic [PC_W-1:0] PC_SETUP_MD = 4'd4;
  localparam logic [PC_W-1:0] PC_MOD_LOOP = 4'd5;
  localparam logic [PC_W-1:0] PC_SETUP_DV = 4'd6;
  localparam logic [PC_W-1:0] PC_DIV_LOOP = 4'd7;
  localparam logic [PC_W-1:0] PC_APPLY    = 4'd8;
  localparam logic [PC_W-1:0] PC_EMIT     = 4'd9;

  // Control store: one control word per program step.
  function automatic uword_t ucode_rom(logic [PC_W-1:0] pc);
    uword_t w;
    case (pc)
      PC_IDLE:     w = '{op: OP_TICK,      cond: JC_WAIT_IN,   target: PC_IDLE};
      PC_BTN_UP:   w = '{op: OP_BTN_UP,    cond: JC_NEXT,      target: PC_IDLE};
      PC_BTN_DN:   w = '{op: OP_BTN_DN,    cond: JC_NEXT,      target: PC_IDLE};
      PC_CHK_MODE: w = '{op: OP_NONE,      cond: JC_MODE_OFF,  target: PC_EMIT};
      PC_SETUP_MD: w = '{op: OP_SETUP_MOD, cond: JC_CYCLE_OFF, target: PC_SETUP_DV};
      PC_MOD_LOOP: w = '{op: OP_DIV,       cond: JC_LOOP,      target: PC_MOD_LOOP};
      PC_SETUP_DV: w = '{op: OP_SETUP_DIV, cond: JC_NEXT,      target: PC_IDLE};
      PC_DIV_LOOP: w = '{op: OP_DIV,       cond: JC_LOOP,      target: PC_DIV_LOOP};
      PC_APPLY:    w = '{op: OP_APPLY,     cond: JC_NEXT,      target: PC_IDLE};
      PC_EMIT:     w = '{op: OP_EMIT,      cond: JC_WAIT_OUT,  target: PC_IDLE};
      default:     w = '{op: OP_NONE,      cond: JC_ALWAYS,    target: PC_IDLE};
    endcase
    return w;
  endfunction

endpackage

>>> hw/rtl/two_button_dimmer_controller_top.sv
`timescale 1ns / 1ps
// Two-button dimmer controller: microcoded sequencer with shared bit-serial divider.
// Sequence: an accepted tick runs the up and down button steps and the mode check; when
//   not dimming it goes straight to emit, else the one-bit-per-cycle restoring divider runs
//   the modulo by the ramp cycle length (skipped when it is zero) and the step divide, then
//   applies the level. A new tick is refused until the program returns to its idle step and is
//   taken then, even while the previous result still waits in the output register.
// Reset: asynchronous, active low; clears time, buttons and mode, brightness to 0,
//   remembered on level to 255, pending PWM update set, configuration to defaults.
module two_button_dimmer_controller_top #(
  parameter int unsigned TIME_BITS = tbdc_pkg::TIME_BITS_DEF
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  // tick transactions
  input  logic                           in_valid_i,
  output logic                           in_stall_o,
  input  logic                           up_level_i,
  input  logic                           down_level_i,
  // result transactions
  output logic                           out_valid_o,
  input  logic                           out_stall_i,
  output logic [7:0]                     level_o,
  output logic                           update_o,
  output logic [1:0]                     mode_o,
  // configuration writes
  input  logic                           cfg_we_i,
  input  logic [tbdc_pkg::CFG_IDX_W-1:0] cfg_index_i,
  input  logic [tbdc_pkg::CFG_W-1:0]     cfg_data_i
);
  import tbdc_pkg::*;

  localparam int unsigned CNT_W = $clog2(TIME_BITS);

  // Sequencer
  logic [PC_W-1:0] pc_q, pc_d;
  uword_t          uw;
  logic            in_acc, out_busy, hold;

  // Configuration
  logic [CFG_W-1:0]  deb_q, deb_d;
  logic [CFG_W-1:0]  short_q, short_d;
  logic [CFG_W-1:0]  cycle_q, cycle_d;
  logic [STEP_W-1:0] step_q, step_d;

  // Controller state
  logic [TIME_BITS-1:0] time_q, time_d;
  logic                 up_lvl_q, up_lvl_d, dn_lvl_q, dn_lvl_d;
  logic                 up_pr_q, up_pr_d, dn_pr_q, dn_pr_d;
  logic [TIME_BITS-1:0] up_at_q, up_at_d, dn_at_q, dn_at_d;
  logic [1:0]           mode_q, mode_d;
  logic [7:0]           bri_q, bri_d, lap_q, lap_d, last_on_q, last_on_d;
  logic [TIME_BITS-1:0] start_q, start_d;
  logic                 upd_q, upd_d;

  // Divider
  logic [TIME_BITS-1:0] dvd_q, dvd_d;
  logic [CFG_W-1:0]     rem_q, rem_d, div_q, div_d;
  logic [CNT_W-1:0]     cnt_q, cnt_d;
  logic [CFG_W:0]       rem_sh, rem_sub;
  logic                 rem_ge;

  // Output register
  logic       out_valid_q, out_valid_d;
  logic [7:0] out_level_q, out_level_d;
  logic       out_upd_q, out_upd_d;
  logic [1:0] out_mode_q, out_mode_d;

  // Button step helpers
  logic                 sel_up, b_lvl, b_pr, b_want, b_fire;
  logic [TIME_BITS-1:0] b_at, b_since;
  logic [1:0]           b_dir;
  logic [7:0]           n_up, n_dn, steps;

  assign uw         = ucode_rom(pc_q);
  assign in_stall_o = (pc_q != PC_IDLE);
  assign in_acc     = in_valid_i && !in_stall_o;
  assign out_busy   = out_valid_q && out_stall_i;
  // Hold the current step while waiting on either channel.
  assign hold       = ((uw.cond == JC_WAIT_IN) && !in_acc) ||
                      ((uw.cond == JC_WAIT_OUT) && out_busy);

  // Next step address.
  always_comb begin
    case (uw.cond)
      JC_NEXT:      pc_d = pc_q + 1'b1;
      JC_WAIT_IN:   pc_d = in_acc ? pc_q + 1'b1 : pc_q;
      JC_MODE_OFF:  pc_d = (mode_q == MODE_CONST) ? uw.target : pc_q + 1'b1;
      JC_CYCLE_OFF: pc_d = (cycle_q == '0) ? uw.target : pc_q + 1'b1;
      JC_LOOP:      pc_d = (cnt_q != '0) ? uw.target : pc_q + 1'b1;
      JC_WAIT_OUT:  pc_d = out_busy ? pc_q : uw.target;
      JC_ALWAYS:    pc_d = uw.target;
      default:      pc_d = PC_IDLE;
    endcase
  end

  // Button debounce and edge handling, shared by both buttons.
  assign sel_up  = (uw.op == OP_BTN_UP);
  assign b_lvl   = sel_up ? up_lvl_q : dn_lvl_q;
  assign b_pr    = sel_up ? up_pr_q : dn_pr_q;
  assign b_at    = sel_up ? up_at_q : dn_at_q;
  assign b_dir   = sel_up ? MODE_UP : MODE_DOWN;
  assign b_want  = !b_lvl;
  assign b_since = time_q - b_at;
  assign b_fire  = (b_want != b_pr) && (b_since > TIME_BITS'(deb_q));

  // One restoring division step: shift in the next dividend bit, subtract if it fits.
  assign rem_sh  = {rem_q, dvd_q[TIME_BITS-1]};
  assign rem_ge  = (rem_sh >= {1'b0, div_q});
  assign rem_sub = rem_sh - {1'b0, div_q};

  // Ramp level from the low quotient byte.
  assign steps = dvd_q[7:0];
  assign n_up  = lap_q + steps;
  assign n_dn  = lap_q - steps;

  always_comb begin
    time_d      = time_q;
    up_lvl_d    = up_lvl_q;
    dn_lvl_d    = dn_lvl_q;
    up_pr_d     = up_pr_q;
    dn_pr_d     = dn_pr_q;
    up_at_d     = up_at_q;
    dn_at_d     = dn_at_q;
    mode_d      = mode_q;
    bri_d       = bri_q;
    lap_d       = lap_q;
    last_on_d   = last_on_q;
    start_d     = start_q;
    upd_d       = upd_q;
    dvd_d       = dvd_q;
    rem_d       = rem_q;
    div_d       = div_q;
    cnt_d       = cnt_q;
    out_level_d = out_level_q;
    out_upd_d   = out_upd_q;
    out_mode_d  = out_mode_q;
    out_valid_d = out_stall_i ? out_valid_q : 1'b0;
    deb_d       = deb_q;
    short_d     = short_q;
    cycle_d     = cycle_q;
    step_d      = step_q;

    if (!hold) begin
      case (uw.op)
        OP_TICK: begin
          // Advance time and capture the raw pin levels.
          time_d   = time_q + 1'b1;
          up_lvl_d = up_level_i;
          dn_lvl_d = down_level_i;
        end
        OP_BTN_UP, OP_BTN_DN: begin
          if (b_fire) begin
            if (sel_up) begin
              up_pr_d = b_want;
              up_at_d = time_q;
            end else begin
              dn_pr_d = b_want;
              dn_at_d = time_q;
            end
            start_d = time_q;
            if (b_want) begin
              // Press: start dimming from the current level.
              lap_d  = bri_q;
              mode_d = b_dir;
            end else begin
              mode_d = MODE_CONST;
              // Short click toggles the lamp.
              if (b_since < TIME_BITS'(short_q)) begin
                if (lap_q == LEVEL_MIN) begin
                  bri_d = last_on_q;
                end else begin
                  last_on_d = lap_q;
                  bri_d     = LEVEL_MIN;
                end
                upd_d = 1'b1;
              end
            end
          end
        end
        OP_SETUP_MOD: begin
          // Elapsed ramp time, reduced modulo the cycle length next.
          dvd_d = time_q - start_q;
          rem_d = '0;
          div_d = cycle_q;
          cnt_d = CNT_W'(TIME_BITS - 1);
        end
        OP_DIV: begin
          rem_d = rem_ge ? rem_sub[CFG_W-1:0] : rem_sh[CFG_W-1:0];
          dvd_d = {dvd_q[TIME_BITS-2:0], rem_ge};
          cnt_d = cnt_q - 1'b1;
        end
        OP_SETUP_DIV: begin
          // Divide by the step time; a zero step counts as one millisecond.
          div_d = (step_q == '0) ? CFG_W'(1) : CFG_W'(step_q);
          rem_d = '0;
          if (cycle_q != '0) begin
            // Remainder fits 16 bits: run only those bits through the divider.
            dvd_d = TIME_BITS'(rem_q) << (TIME_BITS - CFG_W);
            cnt_d = CNT_W'(CFG_W - 1);
          end else begin
            cnt_d = CNT_W'(TIME_BITS - 1);
          end
        end
        OP_APPLY: begin
          // Clamp when the ramp wraps past the current level.
          if (mode_q == MODE_UP) begin
            bri_d = (n_up < bri_q) ? LEVEL_MAX : n_up;
          end else begin
            bri_d = (n_dn > bri_q) ? LEVEL_MIN : n_dn;
          end
          upd_d = 1'b1;
        end
        OP_EMIT: begin
          out_valid_d = 1'b1;
          out_level_d = bri_q;
          out_upd_d   = upd_q;
          out_mode_d  = mode_q;
          upd_d       = 1'b0;
        end
        default: begin
        end
      endcase
    end

    // Configuration writes must arrive only while the sequencer is idle; the block does not enforce it.
    if (cfg_we_i) begin
      case (cfg_index_i)
        REG_DEBOUNCE: deb_d     = cfg_data_i;
        REG_SHORT:    short_d   = cfg_data_i;
        REG_CYCLE:    cycle_d   = cfg_data_i;
        REG_STEP:     step_d    = cfg_data_i[STEP_W-1:0];
        REG_ON_LEVEL: last_on_d = cfg_data_i[7:0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pc_q        <= PC_IDLE;
      deb_q       <= DEBOUNCE_RST;
      short_q     <= SHORT_RST;
      cycle_q     <= CYCLE_RST;
      step_q      <= STEP_RST;
      time_q      <= '0;
      up_lvl_q    <= 1'b1;
      dn_lvl_q    <= 1'b1;
      up_pr_q     <= 1'b0;
      dn_pr_q     <= 1'b0;
      up_at_q     <= '0;
      dn_at_q     <= '0;
      mode_q      <= MODE_CONST;
      bri_q       <= LEVEL_MIN;
      lap_q       <= LEVEL_MIN;
      last_on_q   <= ON_LEVEL_RST;
      start_q     <= '0;
      upd_q       <= 1'b1;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      pc_q        <= pc_d;
      deb_q       <= deb_d;
      short_q     <= short_d;
      cycle_q     <= cycle_d;
      step_q      <= step_d;
      time_q      <= time_d;
      up_lvl_q    <= up_lvl_d;
      dn_lvl_q    <= dn_lvl_d;
      up_pr_q     <= up_pr_d;
      dn_pr_q     <= dn_pr_d;
      up_at_q     <= up_at_d;
      dn_at_q     <= dn_at_d;
      mode_q      <= mode_d;
      bri_q       <= bri_d;
      lap_q       <= lap_d;
      last_on_q   <= last_on_d;
      start_q     <= start_d;
      upd_q       <= upd_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Datapath and result payload: no reset needed.
  always_ff @(posedge clk_i) begin
    dvd_q       <= dvd_d;
    rem_q       <= rem_d;
    div_q       <= div_d;
    out_level_q <= out_level_d;
    out_upd_q   <= out_upd_d;
    out_mode_q  <= out_mode_d;
  end

  assign out_valid_o = out_valid_q;
  assign level_o     = out_level_q;
  assign update_o    = out_upd_q;
  assign mode_o      = out_mode_q;

endmodule

>>> hw/rtl/tbdc_checker.sv
`timescale 1ns / 1ps
// Port-level assertions for the two-button dimmer controller, bound to the top level.
module tbdc_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       in_valid_i,
  input logic       in_stall_o,
  input logic       out_valid_o,
  input logic       out_stall_i,
  input logic [7:0] level_o,
  input logic       update_o,
  input logic [1:0] mode_o
);
  import tbdc_pkg::*;

  // Busy after taking a tick: no second transaction in the next cycle.
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |=> in_stall_o)
    else $error("tick taken while previous one still in work");

  // Every tick while dimming must refresh the PWM.
  a_update_while_dimming: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && (mode_o != MODE_CONST)) |-> update_o)
    else $error("dimming result without PWM update");

  // Stalled result holds.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_stall_i) |=>
      (out_valid_o && $stable(level_o) && $stable(update_o) && $stable(mode_o)))
    else $error("stalled result changed");

endmodule

bind two_button_dimmer_controller_top tbdc_checker u_tbdc_checker (.*);

>>> tb/two_button_dimmer_controller_top_tb.sv
`timescale 1ns / 1ps
// Self-checking testbench of the two-button dimmer controller: directed table, then random gestures.
module two_button_dimmer_controller_top_tb;
  import tbdc_pkg::*;

  localparam int unsigned WATCHDOG_LIMIT = 5000;  // cycles without any accepted transaction
  localparam int unsigned SETTLE_CYCLES  = 100;   // above the worst-case tick latency
  localparam int unsigned TICK_TARGET    = 850;
  localparam int unsigned PLAN_ROWS      = 41;
  localparam int unsigned HOLD_OFF_AFTER = 300;   // results checked before the long sink stall
  localparam int unsigned HOLD_OFF_LEN   = 600;
  localparam int          BTN_UP         = 0;
  localparam int          BTN_DN         = 1;

  // One result transaction: what the lamp channel reports per millisecond tick.
  typedef struct packed {
    logic [7:0] level;
    logic       update;
    logic [1:0] mode;
  } lamp_out_t;

  // One row of the directed table: either a register write or a tick, the latter with an
  // optional hand-typed expectation.
  typedef struct packed {
    bit                   is_wr;
    logic [CFG_IDX_W-1:0] idx;
    logic [CFG_W-1:0]     data;
    bit                   up;
    bit                   dn;
    bit                   fixed;
    lamp_out_t            want;
  } plan_row_t;

  logic                 clk_i;
  logic                 rst_ni;
  logic                 in_valid_i;
  logic                 in_stall_o;
  logic                 up_level_i;
  logic                 down_level_i;
  logic                 out_valid_o;
  logic                 out_stall_i;
  logic [7:0]           level_o;
  logic                 update_o;
  logic [1:0]           mode_o;
  logic                 cfg_we_i;
  logic [CFG_IDX_W-1:0] cfg_index_i;
  logic [CFG_W-1:0]     cfg_data_i;

  two_button_dimmer_controller_top u_top (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .up_level_i  (up_level_i),
    .down_level_i(down_level_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .level_o     (level_o),
    .update_o    (update_o),
    .mode_o      (mode_o),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i)
  );

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  // ---------------------------------------------------------------------------------------
  // Lamp predictor: its own copy of the configuration and of the controller state.
  // ---------------------------------------------------------------------------------------
  logic [15:0]       cfg_debounce;
  logic [15:0]       cfg_short;
  logic [15:0]       cfg_cycle;
  logic [STEP_W-1:0] cfg_step;

  logic [31:0] clk_ms;          // millisecond counter, one count per tick
  bit          btn_held [2];    // debounced pressed state per button
  logic [31:0] btn_changed [2]; // time of the last accepted change per button
  logic [1:0]  ramp_mode;
  logic [7:0]  lamp;
  logic [7:0]  press_level;
  logic [7:0]  saved_on;
  logic [31:0] ramp_start;
  bit          pwm_dirty;

  lamp_out_t   lamp_expect_q [$];
  int unsigned ticks_sent;
  int unsigned results_checked;
  int unsigned mismatches;
  bit          calm;       // sender offers back to back for the whole phase
  bit          held_off;   // long sink stall already done

  task automatic lamp_reset();
    cfg_debounce   = DEBOUNCE_RST;
    cfg_short      = SHORT_RST;
    cfg_cycle      = CYCLE_RST;
    cfg_step       = STEP_RST;
    clk_ms         = '0;
    btn_held[0]    = 1'b0;
    btn_held[1]    = 1'b0;
    btn_changed[0] = '0;
    btn_changed[1] = '0;
    ramp_mode      = MODE_CONST;
    lamp           = LEVEL_MIN;
    press_level    = LEVEL_MIN;
    saved_on       = ON_LEVEL_RST;
    ramp_start     = '0;
    pwm_dirty      = 1'b1;
  endtask

  function automatic void apply_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] data);
    case (idx)
      REG_DEBOUNCE: cfg_debounce = data;
      REG_SHORT:    cfg_short    = data;
      REG_CYCLE:    cfg_cycle    = data;
      REG_STEP:     cfg_step     = data[STEP_W-1:0];
      REG_ON_LEVEL: saved_on     = data[7:0];   // reloads the remembered on level too
      default: ;                                // unknown index: drop the write
    endcase
  endfunction

  // Debounce one button and act on an accepted press or release.
  function automatic void button_edge(int b, bit pin, logic [1:0] dir, logic [31:0] now);
    bit          want;
    logic [31:0] since;
    want  = !pin;
    since = now - btn_changed[b];
    if (want == btn_held[b] || since <= cfg_debounce) return;
    btn_held[b] = want;
    if (want) begin
      press_level = lamp;
      ramp_start  = now;
      ramp_mode   = dir;
    end else begin
      // short click toggles: on at the remembered level, or remember and go dark
      if (since < cfg_short) begin
        if (press_level == LEVEL_MIN) begin
          lamp = saved_on;
        end else begin
          saved_on = press_level;
          lamp     = LEVEL_MIN;
        end
        pwm_dirty = 1'b1;
      end
      ramp_start = now;
      ramp_mode  = MODE_CONST;
    end
    btn_changed[b] = now;
  endfunction

  function automatic lamp_out_t lamp_predict(bit up_pin, bit dn_pin);
    lamp_out_t   o;
    logic [31:0] now;
    logic [31:0] t;
    logic [31:0] div;
    logic [7:0]  steps;
    logic [7:0]  n;
    clk_ms = clk_ms + 1;
    now    = clk_ms;
    button_edge(BTN_UP, up_pin, MODE_UP, now);
    button_edge(BTN_DN, dn_pin, MODE_DOWN, now);
    if (ramp_mode != MODE_CONST) begin
      t = now - ramp_start;
      if (cfg_cycle != 0) t = t % cfg_cycle;   // zero cycle length: use full elapsed time
      div   = (cfg_step != 0) ? cfg_step : 1;  // zero step time counts as one ms
      steps = 8'(t / div);
      if (ramp_mode == MODE_UP) begin
        n    = press_level + steps;
        lamp = (n < lamp) ? LEVEL_MAX : n;
      end else begin
        n    = press_level - steps;
        lamp = (n > lamp) ? LEVEL_MIN : n;
      end
      pwm_dirty = 1'b1;
    end
    o.level   = lamp;
    o.update  = pwm_dirty;
    o.mode    = ramp_mode;
    pwm_dirty = 1'b0;
    return o;
  endfunction

  // ---------------------------------------------------------------------------------------
  // Directed table helpers.
  // ---------------------------------------------------------------------------------------
  function automatic plan_row_t wr(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] data);
    plan_row_t r;
    r       = '0;
    r.is_wr = 1'b1;
    r.idx   = idx;
    r.data  = data;
    return r;
  endfunction

  function automatic plan_row_t tick(bit up, bit dn);
    plan_row_t r;
    r    = '0;
    r.up = up;
    r.dn = dn;
    return r;
  endfunction

  function automatic plan_row_t tick_x(bit up, bit dn, logic [7:0] lvl, logic upd,
                                       logic [1:0] m);
    plan_row_t r;
    r       = tick(up, dn);
    r.fixed = 1'b1;
    r.want  = '{level: lvl, update: upd, mode: m};
    return r;
  endfunction

  plan_row_t plan [PLAN_ROWS];

  // ---------------------------------------------------------------------------------------
  // Sender side.
  // ---------------------------------------------------------------------------------------
  // Mostly back to back, some short gaps, a few long ones.
  function automatic int pick_gap();
    int r;
    if (calm) return 0;
    r = $urandom_range(0, 99);
    if (r < 65) return 0;
    if (r < 94) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // Offer one tick, hold it until accepted, then record what the lamp should report.
  task automatic send_tick(bit up, bit dn, int gap, bit fixed, lamp_out_t want);
    lamp_out_t got;
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i   <= 1'b1;
    up_level_i   <= up;
    down_level_i <= dn;
    do @(posedge clk_i); while (in_stall_o);
    got = lamp_predict(up, dn);
    lamp_expect_q.push_back(fixed ? want : got);
    ticks_sent++;
  endtask

  // Drop valid, drain all outstanding results, then let the sequencer go idle.
  task automatic settle();
    in_valid_i <= 1'b0;
    while (lamp_expect_q.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] data);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    @(posedge clk_i);
    apply_reg(idx, data);
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
  endtask

  // Pick a new register set for one random phase; mostly short times so that
  // presses, clicks and ramps all happen within a few dozen ticks.
  task automatic pick_settings();
    int          r;
    logic [15:0] d;
    r = $urandom_range(0, 9);
    d = 16'((r < 6) ? $urandom_range(0, 3) : (r < 9) ? $urandom_range(4, 15) :
            $urandom_range(16, 60));
    write_reg(REG_DEBOUNCE, d);
    r = $urandom_range(0, 9);
    d = (r == 0) ? 16'd0 : (r == 1) ? 16'hFFFF :
        16'($urandom_range(cfg_debounce + 1, cfg_debounce + 40));
    write_reg(REG_SHORT, d);
    r = $urandom_range(0, 9);
    d = (r < 2) ? 16'd0 : (r == 2) ? 16'hFFFF : 16'($urandom_range(1, 300));
    write_reg(REG_CYCLE, d);
    r = $urandom_range(0, 9);
    d = 16'($urandom);   // random bits above the step field must be dropped
    d[STEP_W-1:0] = (r < 2) ? 13'd0 : (r == 2) ? 13'h1FFF : (r == 3) ? 13'd4096 :
                    13'($urandom_range(1, 6));
    write_reg(REG_STEP, d);
    r = $urandom_range(0, 9);
    d = 16'($urandom);
    d[7:0] = (r < 2) ? LEVEL_MIN : (r < 4) ? LEVEL_MAX : 8'($urandom);
    write_reg(REG_ON_LEVEL, d);
    if ($urandom_range(0, 3) == 0) write_reg(CFG_IDX_W'($urandom_range(5, 7)), 16'($urandom));
  endtask

  // One button gesture: optional contact bounce, a press of random length, then a release
  // long enough to clear the debounce time. A few gestures are plain noise.
  task automatic run_gesture();
    int kind;
    int hold;
    int rel;
    int bounce;
    int lim;
    int i;
    bit pr;
    bit up;
    bit dn;
    kind   = $urandom_range(0, 9);
    lim    = 2 * cfg_short + 6;
    if (lim > 120) lim = 120;
    hold   = $urandom_range(1, lim);
    rel    = cfg_debounce + $urandom_range(1, 8);
    bounce = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 4) : 0;
    for (i = 0; i < bounce + hold + rel; i++) begin
      pr = (i < bounce) ? 1'($urandom_range(0, 1)) : (i < bounce + hold);
      up = 1'b1;
      dn = 1'b1;
      case (kind)
        0, 1, 2, 3: up = !pr;
        4, 5, 6:    dn = !pr;
        7: begin
          up = !pr;
          dn = !pr;
        end
        8: begin
          // down overlaps the second half of the up press
          up = !pr;
          dn = !(i >= bounce + hold / 2 && i < bounce + hold + rel / 2);
        end
        default: begin
          up = 1'($urandom_range(0, 1));
          dn = 1'($urandom_range(0, 1));
        end
      endcase
      send_tick(up, dn, pick_gap(), 1'b0, '0);
    end
  endtask

  // ---------------------------------------------------------------------------------------
  // Stimulus: reset, directed table, random phases, drain, verdict.
  // ---------------------------------------------------------------------------------------
  initial begin : stimulus
    int          r;
    int unsigned phase_end;
    in_valid_i   <= 1'b0;
    up_level_i   <= 1'b1;
    down_level_i <= 1'b1;
    cfg_we_i     <= 1'b0;
    cfg_index_i  <= REG_DEBOUNCE;
    cfg_data_i   <= '0;
    rst_ni       <= 1'b0;
    ticks_sent      = 0;
    mismatches      = 0;
    calm            = 1'b0;
    lamp_reset();

    plan = '{
      // reset state: dark, update pending, then nothing more to write
      tick_x(1'b1, 1'b1, LEVEL_MIN, 1'b1, MODE_CONST),
      // both pressed inside the reset debounce window: ignored
      tick_x(1'b0, 1'b0, LEVEL_MIN, 1'b0, MODE_CONST),
      tick(1'b1, 1'b1),
      // no debounce, every release short, zero cycle length and zero step time
      wr(REG_DEBOUNCE, 16'd0),
      wr(REG_SHORT, 16'hFFFF),
      wr(REG_CYCLE, 16'd0),
      wr(REG_STEP, 16'd0),
      tick_x(1'b0, 1'b1, LEVEL_MIN, 1'b1, MODE_UP),
      tick(1'b0, 1'b1),
      tick(1'b0, 1'b1),
      // short click from dark: on at the remembered full level
      tick_x(1'b1, 1'b1, LEVEL_MAX, 1'b1, MODE_CONST),
      tick(1'b1, 1'b0),
      tick(1'b1, 1'b0),
      // up pressed while down still held, then both released together
      tick(1'b0, 1'b0),
      tick(1'b1, 1'b1),
      // largest step and cycle, never a short click, remembered level 0, unknown indexes
      wr(REG_STEP, 16'hFFFF),
      wr(REG_CYCLE, 16'hFFFF),
      wr(REG_SHORT, 16'd0),
      wr(REG_ON_LEVEL, 16'hAB00),
      wr(3'd5, 16'h00AA),
      wr(3'd7, 16'hFFFF),
      tick(1'b0, 1'b1),
      tick(1'b1, 1'b1),
      wr(REG_SHORT, 16'd100),
      tick(1'b0, 1'b1),
      tick(1'b1, 1'b1),
      // largest debounce: every pin change is ignored
      wr(REG_DEBOUNCE, 16'hFFFF),
      tick_x(1'b0, 1'b0, LEVEL_MIN, 1'b0, MODE_CONST),
      tick_x(1'b1, 1'b1, LEVEL_MIN, 1'b0, MODE_CONST),
      // one-ms cycle pins the ramp; then a three-ms cycle wraps the up ramp past 255
      wr(REG_DEBOUNCE, 16'd0),
      wr(REG_CYCLE, 16'd1),
      wr(REG_STEP, 16'd1),
      wr(REG_ON_LEVEL, 16'h00FF),
      tick(1'b1, 1'b0),
      tick(1'b1, 1'b0),
      tick(1'b1, 1'b1),
      wr(REG_CYCLE, 16'd3),
      tick(1'b0, 1'b1),
      tick(1'b0, 1'b1),
      tick(1'b0, 1'b1),
      tick(1'b1, 1'b1)
    };

    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;

    for (r = 0; r < PLAN_ROWS; r++) begin
      if (plan[r].is_wr) begin
        settle();
        write_reg(plan[r].idx, plan[r].data);
      end else begin
        send_tick(plan[r].up, plan[r].dn, pick_gap(), plan[r].fixed, plan[r].want);
      end
    end

    // Random phases, each with its own register set and sender pacing.
    while (ticks_sent < TICK_TARGET) begin
      settle();
      pick_settings();
      calm      = ($urandom_range(0, 3) == 0);
      phase_end = ticks_sent + $urandom_range(80, 140);
      while (ticks_sent < phase_end) run_gesture();
    end

    settle();
    if (mismatches == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

  // ---------------------------------------------------------------------------------------
  // Sink side: random stalls, one long hold-off that backs the block up, result checking.
  // ---------------------------------------------------------------------------------------
  task automatic check_result();
    lamp_out_t e;
    results_checked++;
    if (lamp_expect_q.size() == 0) begin
      $display("%0t: unexpected result: level %0d update %0d mode %0d", $time, level_o,
               update_o, mode_o);
      mismatches++;
    end else begin
      e = lamp_expect_q.pop_front();
      if (level_o !== e.level) begin
        $display("%0t: level: expected %0d, actual %0d", $time, e.level, level_o);
        mismatches++;
      end
      if (update_o !== e.update) begin
        $display("%0t: update: expected %0d, actual %0d", $time, e.update, update_o);
        mismatches++;
      end
      if (mode_o !== e.mode) begin
        $display("%0t: mode: expected %0d, actual %0d", $time, e.mode, mode_o);
        mismatches++;
      end
    end
  endtask

  task automatic sink_cycle(bit stall);
    out_stall_i <= stall;
    @(posedge clk_i);
    if (out_valid_o && !out_stall_i) check_result();
  endtask

  initial begin : result_sink
    int free_n;
    int hold_n;
    int k;
    results_checked = 0;
    held_off        = 1'b0;
    forever begin
      free_n = $urandom_range(0, 24);
      for (k = 0; k < free_n; k++) sink_cycle(1'b0);
      // hold off long once, while the sender keeps offering, so the input stalls
      if (!held_off && results_checked >= HOLD_OFF_AFTER) begin
        held_off = 1'b1;
        hold_n   = HOLD_OFF_LEN;
      end else begin
        hold_n = ($urandom_range(0, 9) == 0) ? $urandom_range(15, 60) : $urandom_range(1, 3);
      end
      for (k = 0; k < hold_n; k++) sink_cycle(1'b1);
    end
  end

  // ---------------------------------------------------------------------------------------
  // Watchdog: abort when no transaction moves on either channel for too long.
  // ---------------------------------------------------------------------------------------
  int unsigned quiet_cycles = 0;

  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

endmodule

>>> two_button_dimmer_controller_top.f
hw/rtl/tbdc_pkg.sv
hw/rtl/two_button_dimmer_controller_top.sv
hw/rtl/tbdc_checker.sv
tb/two_button_dimmer_controller_top_tb.sv
